@@ src/swrl_pkg.sv @@
// Shared types, field widths and window lengths for the sliding window rate limiter.
`default_nettype none

package swrl_pkg;

	// Fixed widths of the request fields that do not follow a parameter.
	localparam int EVENT_ID_W = 4;
	localparam int EVENT_IDS  = 1 << EVENT_ID_W;
	localparam int LIMIT_W    = 5;

	// Window lengths in seconds; a day needs 17 bits.
	localparam int SECS_PER_SECOND = 1;
	localparam int SECS_PER_MINUTE = 60;
	localparam int SECS_PER_HOUR   = 60 * 60;
	localparam int SECS_PER_DAY    = 24 * 60 * 60;
	localparam int WIN_W           = 17;

	typedef enum logic [1:0] {
		UNIT_SECOND = 2'd0,
		UNIT_MINUTE = 2'd1,
		UNIT_HOUR   = 2'd2,
		UNIT_DAY    = 2'd3
	} unit_t;

	function automatic logic [WIN_W-1:0] win_secs(unit_t unit);
		case (unit)
			UNIT_SECOND: return WIN_W'(SECS_PER_SECOND);
			UNIT_MINUTE: return WIN_W'(SECS_PER_MINUTE);
			UNIT_HOUR:   return WIN_W'(SECS_PER_HOUR);
			UNIT_DAY:    return WIN_W'(SECS_PER_DAY);
			default:     return WIN_W'(SECS_PER_SECOND);
		endcase
	endfunction

endpackage

`default_nettype wire

@@ src/swrl_req_if.sv @@
// Request channel: valid/ready handshake with the rate check fields.
`default_nettype none

interface swrl_req_if #(
	parameter int TIME_BITS = 31
);
	logic                                 valid;
	logic                                 ready;
	logic [TIME_BITS-1:0]                 time_now;
	logic [swrl_pkg::EVENT_ID_W-1:0]      event_id;
	logic [swrl_pkg::LIMIT_W-1:0]         rate_limit;
	swrl_pkg::unit_t                      rate_unit;
	logic                                 count_hit;

	modport source (
		output valid, time_now, event_id, rate_limit, rate_unit, count_hit,
		input  ready
	);

	modport sink (
		input  valid, time_now, event_id, rate_limit, rate_unit, count_hit,
		output ready
	);
endinterface

`default_nettype wire

@@ src/swrl_rsp_if.sv @@
// Response channel: valid/ready handshake with the limited flag.
`default_nettype none

interface swrl_rsp_if;
	logic valid;
	logic ready;
	logic limited;

	modport source (
		output valid, limited,
		input  ready
	);

	modport sink (
		input  valid, limited,
		output ready
	);
endinterface

`default_nettype wire

@@ src/sliding_window_rate_limiter_unit.sv @@
// Sliding window log rate limiter: per-event ring of hit timestamps held in memory.
//
//   channel  direction  handshake      payload
//   req      in         valid/ready    time_now, event_id, rate_limit, rate_unit, count_hit
//   rsp      out        valid/ready    limited
//
// After acceptance a request reads its event table entry, then scans the logged hits of
// its event (at most MAX_HITS) and decides in the finish state, which loads the response
// register. The scan reads one logged timestamp per cycle through the single read port
// of the hit log memory. The unit returns to idle before the next acceptance.
// After reset the event table is cleared one entry per cycle with req.ready low. A new
// request is accepted while a response still waits in the output register; a stalled
// response only holds back the decision of the following request.
`default_nettype none

module sliding_window_rate_limiter_unit #(
	parameter int NUM_EVENTS = 16,
	parameter int MAX_HITS   = 16,
	parameter int TIME_BITS  = 31
) (
	input  wire      clk,
	input  wire      arst_n,
	swrl_req_if.sink   req,
	swrl_rsp_if.source rsp
);
	import swrl_pkg::*;

	// Widths that follow from the parameters.
	localparam int EV_W      = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
	localparam int HW        = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
	localparam int FW        = $clog2(MAX_HITS + 1);
	localparam int LOG_DEPTH = NUM_EVENTS * MAX_HITS;
	localparam int LOG_AW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int SW        = TIME_BITS + 2;
	localparam int LW        = (FW > LIMIT_W) ? FW : LIMIT_W;
	localparam int META_W    = HW + FW;

	// The event id is reduced modulo NUM_EVENTS. The id has only a few bits, so the
	// reduction is a constant table built at elaboration.
	typedef logic [EV_W-1:0] ev_map_t [EVENT_IDS];

	function automatic ev_map_t build_ev_map();
		ev_map_t m;
		for (int i = 0; i < EVENT_IDS; i++) begin
			m[i] = EV_W'(i % NUM_EVENTS);
		end
		return m;
	endfunction

	localparam ev_map_t EV_MAP = build_ev_map();

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_META,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Request held for the duration of its processing.
	logic [EV_W-1:0]          ev_q;
	logic [LOG_AW-1:0]        base_q;
	logic signed [SW-1:0]     start_q;
	logic [TIME_BITS-1:0]     now_q;
	logic [LIMIT_W-1:0]       limit_q;
	logic                     inc_q;

	// Event table entry and scan progress.
	logic [HW-1:0]            head_q;
	logic [FW-1:0]            fill_q;
	logic [FW-1:0]            issue_q;
	logic [FW-1:0]            cnt_q;
	logic                     log_rvld_q;
	logic [EV_W-1:0]          clr_q;

	// Response register.
	logic                     rsp_valid_q;
	logic                     rsp_lim_q;

	// Memories: the hit log and the per-event head/fill table.
	logic [TIME_BITS-1:0]     log_mem [LOG_DEPTH];
	logic [TIME_BITS-1:0]     log_rdata_q;
	logic [META_W-1:0]        meta_mem [NUM_EVENTS];
	logic [META_W-1:0]        meta_rdata_q;

	// Combinational control.
	logic                     req_fire;
	logic [EV_W-1:0]          ev_d;
	logic signed [SW-1:0]     start_d;
	logic                     scan_issue;
	logic                     in_window;
	logic                     lim_d;
	logic                     out_free;
	logic                     finish_go;
	logic [HW-1:0]            head_nxt;
	logic [FW-1:0]            fill_nxt;
	logic [LOG_AW-1:0]        log_raddr;
	logic                     log_we;
	logic [LOG_AW-1:0]        log_waddr;
	logic                     meta_we;
	logic [EV_W-1:0]          meta_waddr;
	logic [META_W-1:0]        meta_wdata;

	assign req.ready   = (state_q == ST_IDLE);
	assign req_fire    = req.valid && req.ready;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.limited = rsp_lim_q;

	assign ev_d = EV_MAP[req.event_id];

	// Window start, kept signed and two bits wider so that it may go below zero.
	assign start_d = signed'({2'b00, req.time_now})
		- signed'(SW'(win_secs(req.rate_unit)))
		+ signed'(SW'(1));

	// One log read per cycle while entries remain; the compare uses last cycle's read.
	assign scan_issue = (state_q == ST_SCAN) && (issue_q != fill_q);
	assign log_raddr  = base_q + LOG_AW'(issue_q[HW-1:0]);
	assign in_window  = signed'({2'b00, log_rdata_q}) >= start_q;

	// Decision once the scan has drained; it waits for the response register to free up.
	assign lim_d     = LW'(cnt_q) >= LW'(limit_q);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign finish_go = (state_q == ST_FINISH) && out_free;

	assign head_nxt = (head_q == HW'(MAX_HITS - 1)) ? '0 : head_q + HW'(1);
	assign fill_nxt = (fill_q < FW'(MAX_HITS)) ? fill_q + FW'(1) : fill_q;

	// A hit is logged only when the request passes and asks to be counted.
	assign log_we    = finish_go && !lim_d && inc_q;
	assign log_waddr = base_q + LOG_AW'(head_q);

	// The event table is written by the clearing pass and by every logged hit.
	assign meta_we    = (state_q == ST_CLEAR) || log_we;
	assign meta_waddr = (state_q == ST_CLEAR) ? clr_q : ev_q;
	assign meta_wdata = (state_q == ST_CLEAR) ? '0 : {head_nxt, fill_nxt};

	always_ff @(posedge clk) begin
		if (log_we) begin
			log_mem[log_waddr] <= now_q;
		end
		log_rdata_q <= log_mem[log_raddr];
	end

	// The table is read at the incoming event on every cycle; the data is consumed in
	// ST_META, in the cycle after acceptance. A write never coincides with that read,
	// since requests are processed one at a time.
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_waddr] <= meta_wdata;
		end
		meta_rdata_q <= meta_mem[ev_d];
	end

	// Request payload registers need no reset.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			ev_q    <= ev_d;
			base_q  <= LOG_AW'(ev_d * MAX_HITS);
			start_q <= start_d;
			now_q   <= req.time_now;
			limit_q <= req.rate_limit;
			inc_q   <= req.count_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			issue_q     <= '0;
			cnt_q       <= '0;
			log_rvld_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_lim_q   <= 1'b0;
		end else begin
			// A new decision loads the response register; otherwise a taken
			// response empties it.
			if (finish_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			log_rvld_q <= scan_issue;

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + EV_W'(1);
					if (clr_q == EV_W'(NUM_EVENTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= ST_META;
					end
				end
				ST_META: begin
					{head_q, fill_q} <= meta_rdata_q;
					issue_q          <= '0;
					cnt_q            <= '0;
					state_q          <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_issue) begin
						issue_q <= issue_q + FW'(1);
					end
					if (log_rvld_q && in_window) begin
						cnt_q <= cnt_q + FW'(1);
					end
					if (!scan_issue && !log_rvld_q) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						rsp_lim_q <= lim_d;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The hit count can never pass the number of entries read so far.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q <= issue_q) && (issue_q <= fill_q))
		else $error("hit count or scan index ran past the event fill");

	// A fill read from the event table never exceeds the ring depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (fill_q <= FW'(MAX_HITS)))
		else $error("event fill above ring depth");

	// An accepted request always moves on to the table read in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q == ST_META) && !req.ready)
		else $error("accepted transaction did not start processing");

	// A decision that finds the response register free loads it.
	assert property (@(posedge clk) disable iff (!arst_n)
		finish_go |=> rsp_valid_q && (rsp_lim_q == $past(lim_d)))
		else $error("response register not loaded on decision");

	// No hit is logged for a request that is limited.
	assert property (@(posedge clk) disable iff (!arst_n)
		log_we |=> !rsp_lim_q)
		else $error("hit logged for a limited transaction");

endmodule

`default_nettype wire

@@ verif/sliding_window_rate_limiter_unit_test.sv @@
// Self-checking testbench for the sliding window rate limiter unit.
`default_nettype none

module sliding_window_rate_limiter_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import swrl_pkg::*;

	localparam int NUM_EVENTS = 16;
	localparam int MAX_HITS   = 16;
	localparam int TIME_BITS  = 31;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	// Window lengths in seconds, indexed by the unit code.
	localparam longint WINDOW_LEN [4] = '{
		longint'(SECS_PER_SECOND), longint'(SECS_PER_MINUTE),
		longint'(SECS_PER_HOUR), longint'(SECS_PER_DAY)
	};

	// One request as it is offered on the request channel.
	typedef struct {
		logic [TIME_BITS-1:0] time_now;
		logic [EVENT_ID_W-1:0] event_id;
		logic [LIMIT_W-1:0]    rate_limit;
		unit_t                 rate_unit;
		logic                  count_hit;
	} rate_req_t;

	logic clk = 1'b0;
	logic arst_n;

	swrl_req_if #(.TIME_BITS(TIME_BITS)) req_ch ();
	swrl_rsp_if rsp_ch ();

	sliding_window_rate_limiter_unit #(
		.NUM_EVENTS(NUM_EVENTS),
		.MAX_HITS  (MAX_HITS),
		.TIME_BITS (TIME_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #4 clk = ~clk;

	// Shadow copy of the per-event hit rings. Only the first fill entries of an
	// event are ever looked at, so entries that were never written stay unused.
	logic [TIME_BITS-1:0] shadow_log [NUM_EVENTS][MAX_HITS];
	logic [3:0]           shadow_head [NUM_EVENTS];
	logic [4:0]           shadow_fill [NUM_EVENTS];

	// Expected limited flags, oldest first, one per accepted transaction.
	logic expected_limited [$];

	int error_count = 0;

	// Idling controls, in percent of cycles. The long hold is timed by a
	// process of its own and only read by the response process.
	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;
	logic recv_hold     = 1'b0;

	// Running time of the well-formed random traffic, and the first of the four
	// event ids that the random traffic concentrates on.
	logic [TIME_BITS-1:0]  flow_time  = '0;
	logic [EVENT_ID_W-1:0] focus_base = '0;

	// Decides one request against the shadow rings and logs the hit when the
	// request passes with count_hit set. Returns the expected limited flag.
	function automatic logic judge_request(rate_req_t r);
		longint               window_start;
		int                   in_window;
		int unsigned          ev;
		logic [3:0]           slot;
		window_start = r.time_now;
		window_start = window_start - WINDOW_LEN[r.rate_unit] + 1;
		ev = r.event_id % NUM_EVENTS;
		in_window = 0;
		for (int i = 0; i < shadow_fill[ev]; i++) begin
			// Logged times are non-negative, so a negative window start
			// simply takes in every logged hit.
			if (longint'(shadow_log[ev][i]) >= window_start)
				in_window++;
		end
		if (in_window >= int'(r.rate_limit))
			return 1'b1;
		if (r.count_hit) begin
			slot = shadow_head[ev];
			shadow_log[ev][slot] = r.time_now;
			shadow_head[ev] = slot + 4'd1;
			if (shadow_fill[ev] < MAX_HITS)
				shadow_fill[ev] = shadow_fill[ev] + 5'd1;
		end
		return 1'b0;
	endfunction

	// Offers one request until it is accepted, records its expected outcome,
	// then may idle the request channel for a random number of cycles.
	task automatic send_request(rate_req_t r);
		req_ch.valid      <= 1'b1;
		req_ch.time_now   <= r.time_now;
		req_ch.event_id   <= r.event_id;
		req_ch.rate_limit <= r.rate_limit;
		req_ch.rate_unit  <= r.rate_unit;
		req_ch.count_hit  <= r.count_hit;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		expected_limited.push_back(judge_request(r));
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct)
				@(posedge clk);
		end
	endtask

	// Stops offering requests and waits until every expected result is in.
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_limited.size() != 0)
			@(posedge clk);
	endtask

	function automatic rate_req_t make_request(logic [TIME_BITS-1:0] t, int ev, int lim,
			unit_t unit, bit hit);
		rate_req_t r;
		r.time_now   = t;
		r.event_id   = EVENT_ID_W'(ev);
		r.rate_limit = LIMIT_W'(lim);
		r.rate_unit  = unit;
		r.count_hit  = hit;
		return r;
	endfunction

	// Mostly well-formed traffic: time moves forward in small steps and the
	// requests crowd onto a few events with small limits, so that windows fill
	// and requests get limited. About one in ten is noise with any field value,
	// including times that run backwards.
	function automatic rate_req_t next_random_request();
		rate_req_t   r;
		int unsigned roll;
		longint      t;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			r.time_now   = TIME_BITS'($urandom);
			r.event_id   = EVENT_ID_W'($urandom);
			r.rate_limit = LIMIT_W'($urandom);
			r.rate_unit  = unit_t'($urandom_range(0, 3));
			r.count_hit  = 1'($urandom);
			return r;
		end
		roll = $urandom_range(0, 99);
		t = flow_time;
		if (roll < 65)
			t = t + $urandom_range(0, 2);
		else if (roll < 88)
			t = t + $urandom_range(0, 90);
		else if (roll < 97)
			t = t + $urandom_range(0, 5000);
		else
			t = t + $urandom_range(0, 200000);
		if (t > longint'(TIME_MAX))
			t = TIME_MAX;
		flow_time = TIME_BITS'(t);
		r.time_now = flow_time;

		if ($urandom_range(0, 99) < 75)
			r.event_id = focus_base + EVENT_ID_W'($urandom_range(0, 3));
		else
			r.event_id = EVENT_ID_W'($urandom);

		roll = $urandom_range(0, 99);
		if (roll < 60)
			r.rate_limit = LIMIT_W'($urandom_range(1, 4));
		else if (roll < 85)
			r.rate_limit = LIMIT_W'($urandom_range(0, MAX_HITS));
		else
			r.rate_limit = LIMIT_W'($urandom);

		roll = $urandom_range(0, 99);
		if (roll < 40)
			r.rate_unit = UNIT_SECOND;
		else if (roll < 70)
			r.rate_unit = UNIT_MINUTE;
		else if (roll < 90)
			r.rate_unit = UNIT_HOUR;
		else
			r.rate_unit = UNIT_DAY;

		r.count_hit = ($urandom_range(0, 99) < 85);
		return r;
	endfunction

	// Sends a block of random requests from a fresh time base and focus set.
	task automatic run_random_items(int count, logic [TIME_BITS-1:0] base_time);
		flow_time  = base_time;
		focus_base = EVENT_ID_W'($urandom);
		repeat (count)
			send_request(next_random_request());
		wait_for_results();
	endtask

	// Hand-picked requests: a zero limit, a limit reached and then released by
	// the window sliding on, requests that are not logged, a ring filled past its
	// depth with a limit above the ring depth, the largest timestamp, and a
	// request whose time lies before a logged hit.
	task automatic test_directed_cases();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_request(make_request(0, 0, 0, UNIT_SECOND, 1'b1));
		send_request(make_request(0, 1, 1, UNIT_SECOND, 1'b1));
		send_request(make_request(0, 1, 1, UNIT_SECOND, 1'b1));
		send_request(make_request(1, 1, 1, UNIT_SECOND, 1'b0));
		send_request(make_request(1, 4, 1, UNIT_MINUTE, 1'b0));
		send_request(make_request(2, 4, 1, UNIT_MINUTE, 1'b0));
		// Seventeen hits on one event overwrite the oldest slot of its ring;
		// the window start is negative here, so every logged hit counts.
		repeat (MAX_HITS + 1)
			send_request(make_request(3, 3, 31, UNIT_HOUR, 1'b1));
		send_request(make_request(4, 3, MAX_HITS, UNIT_HOUR, 1'b1));
		send_request(make_request(TIME_MAX, 15, 31, UNIT_DAY, 1'b1));
		send_request(make_request(100, 15, 1, UNIT_SECOND, 1'b0));
		wait_for_results();
	endtask

	task automatic test_streaming();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random_items(300, TIME_BITS'($urandom_range(0, 1000)));
	endtask

	task automatic test_sender_gaps();
		send_idle_pct  = 60;
		recv_stall_pct = 0;
		run_random_items(300, TIME_BITS'($urandom));
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct  = 0;
		recv_stall_pct = 60;
		run_random_items(300, TIME_BITS'($urandom));
	endtask

	task automatic test_mixed_idling();
		send_idle_pct  = 18;
		recv_stall_pct = 18;
		run_random_items(300, TIME_BITS'($urandom));
	endtask

	// Holds the response side off for the given number of cycles.
	task automatic hold_receiver(int cycles);
		recv_hold <= 1'b1;
		repeat (cycles) @(posedge clk);
		recv_hold <= 1'b0;
	endtask

	// The response side holds off for a long stretch while requests keep
	// coming, so the unit fills up and drops req.ready until the hold ends.
	task automatic test_full_backpressure();
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		fork
			hold_receiver(400);
		join_none
		run_random_items(60, TIME_BITS'($urandom));
	endtask

	// Times close to the top of the range, where the running time saturates.
	task automatic test_top_of_time_range();
		send_idle_pct  = 18;
		recv_stall_pct = 18;
		run_random_items(100, TIME_MAX - TIME_BITS'($urandom_range(0, 100000)));
	endtask

	// Response side: checks each accepted transaction against the oldest
	// expectation, then picks ready for the next cycle. Both read values as
	// they stood at the clock edge, before this edge's updates land.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (expected_limited.size() == 0) begin
					$error("limited: unexpected result %0b with nothing expected",
						rsp_ch.limited);
					error_count++;
				end else begin
					if (rsp_ch.limited !== expected_limited[0]) begin
						$error("limited mismatch: expected %0b, actual %0b",
							expected_limited[0], rsp_ch.limited);
						error_count++;
					end
					void'(expected_limited.pop_front());
				end
			end
			if (recv_hold) begin
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.time_now   <= '0;
		req_ch.event_id   <= '0;
		req_ch.rate_limit <= '0;
		req_ch.rate_unit  <= UNIT_SECOND;
		req_ch.count_hit  <= 1'b0;
		for (int e = 0; e < NUM_EVENTS; e++) begin
			shadow_head[e] = '0;
			shadow_fill[e] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// The unit clears its event table after reset with req.ready low; the
		// first send simply waits for the handshake.

		test_directed_cases();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_idling();
		test_full_backpressure();
		test_top_of_time_range();

		// Give any stray result time to show up before the verdict.
		repeat (4 * (MAX_HITS + 4)) @(posedge clk);
		if (error_count == 0 && expected_limited.size() == 0) begin
			$display("sliding_window_rate_limiter_unit test passed");
		end else begin
			$display("sliding_window_rate_limiter_unit test failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("sliding_window_rate_limiter_unit test failed");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
src/swrl_pkg.sv
src/swrl_req_if.sv
src/swrl_rsp_if.sv
src/sliding_window_rate_limiter_unit.sv
verif/sliding_window_rate_limiter_unit_test.sv
